// ===== rtl/pmpbt_pkg.sv =====
package pmpbt_pkg;

   localparam int COLUMNS   = 8;
   localparam int WINDOW    = 21;
   localparam int ADC_BITS  = 10;

   localparam int COL_W     = 3;
   localparam int POT_W     = 10;
   localparam int PITCH_W   = 7;
   localparam int DEB_W     = 10;
   localparam int TIME_W    = 32;
   localparam int WIN_W     = $clog2(WINDOW + 1);
   localparam int MEM_DEPTH = COLUMNS * WINDOW;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int NUM_W     = POT_W + PITCH_W;
   localparam int DCNT_W    = $clog2(NUM_W + 1);
   localparam int CSR_AW    = 2;

   localparam logic [POT_W-1:0]   RST_MAX_POT   = POT_W'(550);
   localparam logic [PITCH_W-1:0] RST_MAX_PITCH = PITCH_W'(127);
   localparam logic [DEB_W-1:0]   RST_DEBOUNCE  = DEB_W'(50);

   typedef enum logic [CSR_AW-1:0] {
      CSR_MAX_POT   = 2'd0,
      CSR_MAX_PITCH = 2'd1,
      CSR_DEBOUNCE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COL_W-1:0]    column_index;
      logic [ADC_BITS-1:0] sample_a;
      logic [ADC_BITS-1:0] sample_b;
      logic [ADC_BITS-1:0] sample_c;
      logic                button_level;
      logic [TIME_W-1:0]   now_ms;
   } req_word_type;

   typedef struct packed {
      logic [COL_W-1:0]   column_out;
      logic [PITCH_W-1:0] pitch;
      logic [POT_W-1:0]   pot_level;
      logic               enabled;
   } rsp_word_type;

endpackage

// ===== rtl/pot_median_pitch_and_button_toggle.sv =====
// per-column pot smoothing, pitch mapping and debounced on/off toggle
//
// req channel: one word per column scan (column, three adc samples, button
// level, ms timestamp). req_stall is high while a word is being worked on;
// a new word is taken only when the sequencer is idle.
// rsp channel: one word per scan (column, held pitch, held pot level,
// enabled flag), held in an output register until rsp_stall drops. a
// finished word waits in the last step while the output register is full.
// csr channel: valid/ready write port, always ready; writes are meant to
// happen while the block is idle.
// steps from the accepting edge to rsp_valid: write, load, rank, decide,
// map and finish; load and rank sweep the window, whose fill after the
// push is 3..21. decide waits for the deadband division, which starts on
// accept. a median inside the deadband skips the map step. the sequencer
// goes back to idle after finish, so a new word is taken only once the
// last one is through.
// reset is synchronous: all but the datapath registers go to their defaults, all windows empty,
// enabled flags set. the sample memory needs no clearing pass since only
// written entries are ever read.
module pot_median_pitch_and_button_toggle
   import pmpbt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_AW-1:0]  csr_index,
   input  logic [POT_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_LOAD, ST_RANK, ST_DECIDE, ST_MAP, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   req_word_type item_ff, item_in;
   logic [WIN_W-1:0]   cnt_ff, cnt_in;
   logic [WIN_W-1:0]   n_ff, n_in;
   logic [MEM_AW-1:0]  base_ff, base_in;
   logic [ADC_BITS-1:0] med_ff, med_in;

   // bit-serial restoring divider
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [POT_W-1:0]   rem_ff, rem_in;
   logic [POT_W-1:0]   den_ff, den_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic [ADC_BITS-1:0] local_ff [WINDOW];
   logic [ADC_BITS-1:0] local_in [WINDOW];

   logic [WIN_W-1:0]   wcnt_ff [COLUMNS];
   logic [WIN_W-1:0]   wcnt_in [COLUMNS];
   logic [WIN_W-1:0]   head_ff [COLUMNS];
   logic [WIN_W-1:0]   head_in [COLUMNS];
   logic [POT_W-1:0]   hpot_ff [COLUMNS];
   logic [POT_W-1:0]   hpot_in [COLUMNS];
   logic [PITCH_W-1:0] hpitch_ff [COLUMNS];
   logic [PITCH_W-1:0] hpitch_in [COLUMNS];
   logic [COLUMNS-1:0] en_ff, en_in;
   logic [COLUMNS-1:0] stable_ff, stable_in;
   logic [TIME_W-1:0]  ctime_ff [COLUMNS];
   logic [TIME_W-1:0]  ctime_in [COLUMNS];

   logic [POT_W-1:0]   mpv_ff, mpv_in;
   logic [PITCH_W-1:0] maxp_ff, maxp_in;
   logic [DEB_W-1:0]   deb_ff, deb_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // sample memory
   logic [ADC_BITS-1:0] mem [MEM_DEPTH];
   logic [ADC_BITS-1:0] rd_ff;
   logic                mem_we;
   logic [MEM_AW-1:0]   mem_waddr;
   logic [ADC_BITS-1:0] mem_wdata;
   logic [MEM_AW-1:0]   mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   logic [COL_W-1:0]  col;
   logic [POT_W:0]    rem_shift;
   logic              div_ge;
   logic [WINDOW-1:0] less_vec, eq_vec;
   logic [WIN_W-1:0]  less_cnt, eq_cnt, med_pos;
   logic [NUM_W-1:0]  deadband;
   logic [POT_W-1:0]  diff;
   logic [TIME_W-1:0] elapsed;
   logic [WIN_W:0]    fill_sum;

   assign col       = item_ff.column_index;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge    = (rem_shift >= {1'b0, den_ff});
   assign med_pos   = n_ff >> 1;
   assign less_cnt  = WIN_W'($countones(less_vec));
   assign eq_cnt    = WIN_W'($countones(eq_vec));
   assign deadband  = (maxp_ff == '0) ? '0 : num_ff;
   assign diff      = (hpot_ff[col] > med_ff) ? hpot_ff[col] - med_ff
                                              : med_ff - hpot_ff[col];
   assign elapsed   = item_ff.now_ms - ctime_ff[col];
   assign fill_sum  = {1'b0, wcnt_ff[req_word.column_index]} + (WIN_W+1)'(3);

   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         less_vec[j] = (WIN_W'(j) < n_ff) && (local_ff[j] < rd_ff);
         eq_vec[j]   = (WIN_W'(j) < n_ff) && (local_ff[j] == rd_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      med_in       = med_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dcnt_in      = dcnt_ff;
      local_in     = local_ff;
      wcnt_in      = wcnt_ff;
      head_in      = head_ff;
      hpot_in      = hpot_ff;
      hpitch_in    = hpitch_ff;
      en_in        = en_ff;
      stable_in    = stable_ff;
      ctime_in     = ctime_ff;
      mpv_in       = mpv_ff;
      maxp_in      = maxp_ff;
      deb_in       = deb_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;
      mem_waddr    = base_ff + MEM_AW'(head_ff[col]);
      mem_wdata    = item_ff.sample_a;
      mem_raddr    = base_ff + MEM_AW'(cnt_ff);

      // divider step runs whenever a division is in flight
      if (dcnt_ff != '0) begin
         rem_in  = div_ge ? POT_W'(rem_shift - {1'b0, den_ff}) : POT_W'(rem_shift);
         num_in  = {num_ff[NUM_W-2:0], div_ge};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_POT:   mpv_in  = csr_wdata;
            CSR_MAX_PITCH: maxp_in = PITCH_W'(csr_wdata);
            CSR_DEBOUNCE:  deb_in  = DEB_W'(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               base_in  = MEM_AW'(req_word.column_index) * MEM_AW'(WINDOW);
               n_in     = (fill_sum > (WIN_W+1)'(WINDOW)) ? WIN_W'(WINDOW)
                                                          : WIN_W'(fill_sum);
               wcnt_in[req_word.column_index] = n_in;
               cnt_in   = '0;
               // deadband division overlaps the window sweeps
               num_in   = NUM_W'(mpv_ff);
               rem_in   = '0;
               den_in   = POT_W'(maxp_ff);
               dcnt_in  = DCNT_W'(NUM_W);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            case (cnt_ff)
               WIN_W'(0): mem_wdata = item_ff.sample_a;
               WIN_W'(1): mem_wdata = item_ff.sample_b;
               default:   mem_wdata = item_ff.sample_c;
            endcase
            head_in[col] = (head_ff[col] == WIN_W'(WINDOW - 1)) ? '0
                                                                : head_ff[col] + WIN_W'(1);
            cnt_in = cnt_ff + WIN_W'(1);
            if (cnt_ff == WIN_W'(2)) begin
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // read issued at cnt, data lands in rd_ff on the next cycle
            if (cnt_ff != '0) begin
               local_in[cnt_ff - WIN_W'(1)] = rd_ff;
            end
            cnt_in = cnt_ff + WIN_W'(1);
            if (cnt_ff == n_ff) begin
               cnt_in   = '0;
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            if (cnt_ff != '0 && less_cnt <= med_pos
                && (less_cnt + eq_cnt) > med_pos) begin
               med_in = rd_ff;
            end
            cnt_in = cnt_ff + WIN_W'(1);
            if (cnt_ff == n_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (dcnt_ff == '0) begin
               if (NUM_W'(diff) >= deadband) begin
                  hpot_in[col] = med_ff;
                  num_in   = NUM_W'(med_ff) * NUM_W'(maxp_ff);
                  rem_in   = '0;
                  den_in   = (mpv_ff == '0) ? POT_W'(1) : mpv_ff;
                  dcnt_in  = DCNT_W'(NUM_W);
                  state_in = ST_MAP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MAP: begin
            if (dcnt_ff == '0) begin
               hpitch_in[col] = (num_ff >= NUM_W'(maxp_ff)) ? '0
                                : maxp_ff - PITCH_W'(num_ff);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               // debounced button: rising edge toggles the column
               if (stable_ff[col] != item_ff.button_level
                   && elapsed > TIME_W'(deb_ff)) begin
                  stable_in[col] = item_ff.button_level;
                  ctime_in[col]  = item_ff.now_ms;
                  if (item_ff.button_level) begin
                     en_in[col] = ~en_ff[col];
                  end
               end
               rsp_valid_in           = 1'b1;
               rsp_word_in.column_out = col;
               rsp_word_in.pitch      = hpitch_ff[col];
               rsp_word_in.pot_level  = hpot_ff[col];
               rsp_word_in.enabled    = en_in[col];
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dcnt_ff      <= '0;
         cnt_ff       <= '0;
         mpv_ff       <= RST_MAX_POT;
         maxp_ff      <= RST_MAX_PITCH;
         deb_ff       <= RST_DEBOUNCE;
         rsp_valid_ff <= 1'b0;
         en_ff        <= '1;
         stable_ff    <= '0;
         for (int c = 0; c < COLUMNS; c++) begin
            wcnt_ff[c]   <= '0;
            head_ff[c]   <= '0;
            hpot_ff[c]   <= '0;
            hpitch_ff[c] <= '0;
            ctime_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         dcnt_ff      <= dcnt_in;
         cnt_ff       <= cnt_in;
         mpv_ff       <= mpv_in;
         maxp_ff      <= maxp_in;
         deb_ff       <= deb_in;
         rsp_valid_ff <= rsp_valid_in;
         en_ff        <= en_in;
         stable_ff    <= stable_in;
         wcnt_ff      <= wcnt_in;
         head_ff      <= head_in;
         hpot_ff      <= hpot_in;
         hpitch_ff    <= hpitch_in;
         ctime_ff     <= ctime_in;
      end
      item_ff     <= item_in;
      n_ff        <= n_in;
      base_ff     <= base_in;
      med_ff      <= med_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      local_ff    <= local_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
